FILE: hdl/cspd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cycling speed solver package
// Shared widths, constants, register codes, sequencer states and the control
// and status words passed between the sequencer and the datapath.
// ----------------------------------------------------------------------------
package cspd_pkg;

  localparam int SPEED_W   = 21;
  localparam int TGT_W     = 22;
  localparam int CFG_W     = 18;
  localparam int CFG_IDX_W = 3;
  localparam int MUL_W     = 32;
  localparam int PROD_W    = 2 * MUL_W;

  localparam logic [19:0] SPEED_START_Q16 = 20'd637156;
  localparam logic [19:0] GRAV_ROLL_Q16   = 20'd639624;
  localparam logic [9:0]  UW_PER_MW       = 10'd1000;
  localparam logic [9:0]  EFF_FULL        = 10'd1000;
  localparam logic [6:0]  TOL_UW          = 7'd100;
  localparam logic [16:0] FRONT_MASS_MIN  = 17'd50000;
  localparam logic [16:0] FRONT_MASS_MAX  = 17'd100000;

  // Reciprocal of 125 in Q30. It gives exact quotients for dividends below 2^23.
  localparam logic [23:0] KD_RECIP        = 24'd8589935;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RIDER_MASS  = 3'd0,
    REG_BIKE_MASS   = 3'd1,
    REG_ROLLING     = 3'd2,
    REG_DRAG        = 3'd3,
    REG_AIR_DENSITY = 3'd4,
    REG_LOSS        = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic [17:0] rider_mass_g;
    logic [15:0] bike_mass_g;
    logic [15:0] rolling_coef_q16;
    logic [15:0] drag_coef_q16;
    logic [10:0] air_density_gpm3;
    logic [8:0]  drivetrain_loss_tenths;
  } cfg_t;

  typedef enum logic [3:0] {
    MUL_NONE,
    MUL_TGT,
    MUL_DR,
    MUL_MF,
    MUL_TD,
    MUL_GR,
    MUL_ROLL,
    MUL_QH,
    MUL_QL,
    MUL_SQ,
    MUL_CU,
    MUL_KD,
    MUL_LO,
    MUL_HI
  } mul_sel_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_TGT,
    ST_KA,
    ST_KB,
    ST_KC,
    ST_KD,
    ST_KE,
    ST_KF,
    ST_QH,
    ST_QL,
    ST_SQ,
    ST_CU,
    ST_V3,
    ST_LO,
    ST_HI,
    ST_WH,
    ST_WK,
    ST_CMP,
    ST_FIN
  } state_t;

  typedef struct packed {
    mul_sel_t mul_sel;
    logic     ld_tgt;
    logic     ld_t;
    logic     ld_num;
    logic     ld_thr;
    logic     ld_kr;
    logic     ld_qh;
    logic     ld_kd;
    logic     srch_init;
    logic     ld_acc;
    logic     add_lo;
    logic     ld_wheel;
    logic     ld_wk;
    logic     srch_step;
    logic     ld_out;
  } ctrl_t;

  typedef struct packed {
    logic hit;
    logic out_free;
  } stat_t;

endpackage

FILE: hdl/cycling_speed_from_power_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cycling speed solver
// Returns the steady road speed in 2^-16 m/s at which modeled drag, rolling
// resistance and drivetrain loss absorb a given rider power in mW.
// ----------------------------------------------------------------------------
// One word is solved at a time. After its target word is taken, the word runs
// through per-word setup on the single shared 32 by 32 multiplier, two
// reciprocal multiplies that divide the drag constant by 125, then at most
// SEARCH_STEPS search steps of multiplier passes and decisions, and finally a
// load of the output register; the next target word is taken only after that.
// A previous result still stalled on the output holds the new result back
// until it is taken. The search ends early once the modeled power is within
// 0.1 mW of the target. The user must write the registers only while no word
// is in flight; the block itself does not enforce this.
module cycling_speed_from_power_core
  import cspd_pkg::*;
#(
  parameter int SEARCH_STEPS = 25
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 target_valid,
  output logic                 target_stall,
  input  logic [TGT_W-1:0]     target_power_mw,
  output logic                 speed_valid,
  input  logic                 speed_stall,
  output logic [SPEED_W-1:0]   speed_q16
);

  cfg_t              cfg;
  ctrl_t             ctrl;
  stat_t             stat;
  logic [MUL_W-1:0]  mul_a;
  logic [MUL_W-1:0]  mul_b;
  logic [PROD_W-1:0] mul_p;

  cspd_regs u_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  cspd_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (mul_p)
  );

  cspd_seq #(
    .SEARCH_STEPS (SEARCH_STEPS)
  ) u_seq (
    .clk          (clk),
    .rst          (rst),
    .target_valid (target_valid),
    .stat         (stat),
    .target_stall (target_stall),
    .ctrl         (ctrl)
  );

  cspd_dp u_dp (
    .clk             (clk),
    .rst             (rst),
    .cfg             (cfg),
    .ctrl            (ctrl),
    .target_power_mw (target_power_mw),
    .speed_stall     (speed_stall),
    .mul_p           (mul_p),
    .mul_a           (mul_a),
    .mul_b           (mul_b),
    .stat            (stat),
    .speed_valid     (speed_valid),
    .speed_q16       (speed_q16)
  );

endmodule

FILE: hdl/cspd_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cycling speed solver configuration registers
// Holds the rider, bicycle and environment settings written by index.
// ----------------------------------------------------------------------------
module cspd_regs
  import cspd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  output cfg_t                 cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.rider_mass_g           <= 18'd85000;
      cfg.bike_mass_g            <= 16'd9000;
      cfg.rolling_coef_q16       <= 16'd328;
      cfg.drag_coef_q16          <= 16'd41288;
      cfg.air_density_gpm3       <= 11'd1226;
      cfg.drivetrain_loss_tenths <= 9'd30;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_RIDER_MASS:  cfg.rider_mass_g           <= cfg_data;
        REG_BIKE_MASS:   cfg.bike_mass_g            <= cfg_data[15:0];
        REG_ROLLING:     cfg.rolling_coef_q16       <= cfg_data[15:0];
        REG_DRAG:        cfg.drag_coef_q16          <= cfg_data[15:0];
        REG_AIR_DENSITY: cfg.air_density_gpm3       <= cfg_data[10:0];
        REG_LOSS:        cfg.drivetrain_loss_tenths <= cfg_data[8:0];
        default: begin
        end
      endcase
    end
  end

endmodule

FILE: hdl/cspd_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cycling speed solver shared multiplier
// One unsigned 32 by 32 multiplier with a registered 64-bit product.
// ----------------------------------------------------------------------------
module cspd_mul
  import cspd_pkg::*;
(
  input  logic              clk,
  input  logic [MUL_W-1:0]  a,
  input  logic [MUL_W-1:0]  b,
  output logic [PROD_W-1:0] p
);

  always_ff @(posedge clk) begin
    p <= PROD_W'(a) * PROD_W'(b);
  end

endmodule

FILE: hdl/cspd_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cycling speed solver sequencer
// Steps the shared multiplier through the per-word setup, the reciprocal
// divide for the drag constant and the halving search, and counts search steps.
// ----------------------------------------------------------------------------
module cspd_seq
  import cspd_pkg::*;
#(
  parameter int SEARCH_STEPS = 25
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  target_valid,
  input  stat_t stat,
  output logic  target_stall,
  output ctrl_t ctrl
);

  localparam int STEP_W = $clog2(SEARCH_STEPS);
  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(SEARCH_STEPS - 1);

  state_t            state;
  state_t            state_next;
  logic [STEP_W-1:0] step;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= '0;
    end else begin
      if (state == ST_KF) begin
        step <= '0;
      end
      if (state == ST_CMP) begin
        step <= step + 1'b1;
      end
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (target_valid) begin
          state_next = ST_TGT;
        end
      end
      ST_TGT: state_next = ST_KA;
      ST_KA:  state_next = ST_KB;
      ST_KB:  state_next = ST_KC;
      ST_KC:  state_next = ST_KD;
      ST_KD:  state_next = ST_KE;
      ST_KE:  state_next = ST_KF;
      ST_KF:  state_next = ST_QH;
      ST_QH:  state_next = ST_QL;
      ST_QL:  state_next = ST_SQ;
      ST_SQ:  state_next = ST_CU;
      ST_CU:  state_next = ST_V3;
      ST_V3:  state_next = ST_LO;
      ST_LO:  state_next = ST_HI;
      ST_HI:  state_next = ST_WH;
      ST_WH:  state_next = ST_WK;
      ST_WK:  state_next = ST_CMP;
      ST_CMP: begin
        if (stat.hit || step == STEP_LAST) begin
          state_next = ST_FIN;
        end else begin
          state_next = ST_SQ;
        end
      end
      ST_FIN: begin
        if (stat.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl         = '0;
    ctrl.mul_sel = MUL_NONE;
    target_stall = (state != ST_IDLE);
    unique case (state)
      ST_IDLE: ctrl.ld_tgt = target_valid;
      ST_TGT:  ctrl.mul_sel = MUL_TGT;
      ST_KA: begin
        ctrl.ld_t    = 1'b1;
        ctrl.mul_sel = MUL_DR;
      end
      ST_KB:   ctrl.mul_sel = MUL_MF;
      ST_KC: begin
        ctrl.ld_num  = 1'b1;
        ctrl.mul_sel = MUL_TD;
      end
      ST_KD: begin
        ctrl.ld_thr  = 1'b1;
        ctrl.mul_sel = MUL_GR;
      end
      ST_KE:   ctrl.mul_sel = MUL_ROLL;
      ST_KF: begin
        ctrl.ld_kr     = 1'b1;
        ctrl.srch_init = 1'b1;
        ctrl.mul_sel   = MUL_QH;
      end
      ST_QH: begin
        ctrl.ld_qh   = 1'b1;
        ctrl.mul_sel = MUL_QL;
      end
      ST_QL:   ctrl.ld_kd = 1'b1;
      ST_SQ:   ctrl.mul_sel = MUL_SQ;
      ST_CU:   ctrl.mul_sel = MUL_CU;
      ST_V3:   ctrl.mul_sel = MUL_KD;
      ST_LO: begin
        ctrl.ld_acc  = 1'b1;
        ctrl.mul_sel = MUL_LO;
      end
      ST_HI: begin
        ctrl.add_lo  = 1'b1;
        ctrl.mul_sel = MUL_HI;
      end
      ST_WH:   ctrl.ld_wheel = 1'b1;
      ST_WK:   ctrl.ld_wk = 1'b1;
      ST_CMP:  ctrl.srch_step = 1'b1;
      ST_FIN:  ctrl.ld_out = stat.out_free;
      default: begin
      end
    endcase
  end

endmodule

FILE: hdl/cspd_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cycling speed solver datapath
// Operand selection for the shared multiplier, the drag and rolling
// constants, the decision thresholds, the search speed and the output word.
// ----------------------------------------------------------------------------
module cspd_dp
  import cspd_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  cfg_t              cfg,
  input  ctrl_t             ctrl,
  input  logic [TGT_W-1:0]  target_power_mw,
  input  logic              speed_stall,
  input  logic [PROD_W-1:0] mul_p,
  output logic [MUL_W-1:0]  mul_a,
  output logic [MUL_W-1:0]  mul_b,
  output stat_t             stat,
  output logic              speed_valid,
  output logic [SPEED_W-1:0] speed_q16
);

  logic [TGT_W-1:0]   tgt;
  logic [31:0]        t_uw;
  logic [34:0]        dq;
  logic [12:0]        kd_hi;
  logic [27:0]        kd8;
  logic [41:0]        thr_g;
  logic [41:0]        thr_h;
  logic [41:0]        thr_l;
  logic [39:0]        kr8;
  logic [SPEED_W-1:0] speed;
  logic [19:0]        adj;
  logic [33:0]        acc;
  logic [37:0]        wheel;
  logic [47:0]        wk;

  logic [9:0]         dval;
  logic [16:0]        mf;
  logic [18:0]        mass_sum;
  logic [45:0]        p3;
  logic [16:0]        d_tol;
  logic [16:0]        d_tol1;
  logic [48:0]        kr_x1000;
  logic [12:0]        q_hi;
  logic [19:0]        q_hi_rem;
  logic               high;
  logic [SPEED_W-1:0] spd_down;
  logic [SPEED_W-1:0] spd_up;

  always_comb begin
    dval     = EFF_FULL - {1'b0, cfg.drivetrain_loss_tenths};
    mass_sum = {1'b0, cfg.rider_mass_g} + 19'(cfg.bike_mass_g);
    if (cfg.rider_mass_g < 18'(FRONT_MASS_MIN)) begin
      mf = FRONT_MASS_MIN;
    end else if (cfg.rider_mass_g > 18'(FRONT_MASS_MAX)) begin
      mf = FRONT_MASS_MAX;
    end else begin
      mf = cfg.rider_mass_g[16:0];
    end
    p3       = {1'b0, mul_p[43:0], 1'b0} + {2'b0, mul_p[43:0]};
    d_tol    = 17'(dval * TOL_UW);
    d_tol1   = d_tol - 17'(dval);
    kr_x1000 = {mul_p[38:0], 10'b0} - {6'b0, mul_p[38:0], 4'b0}
             - {7'b0, mul_p[38:0], 3'b0};
    q_hi     = mul_p[42:30];
    q_hi_rem = {1'b0, dq[34:16]}
             - ({q_hi, 7'b0} - {6'b0, q_hi, 1'b0} - {7'b0, q_hi});
    stat.hit = (wk >= {6'b0, thr_l}) && (wk < {6'b0, thr_h});
    high     = (wk >= {6'b0, thr_g});
    spd_down = (speed > {1'b0, adj}) ? speed - {1'b0, adj} : '0;
    spd_up   = speed + {1'b0, adj};
    stat.out_free = !speed_valid || !speed_stall;
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (ctrl.mul_sel)
      MUL_TGT: begin
        mul_a = 32'(tgt);
        mul_b = 32'(UW_PER_MW);
      end
      MUL_DR: begin
        mul_a = 32'(cfg.drag_coef_q16);
        mul_b = 32'(cfg.air_density_gpm3);
      end
      MUL_MF: begin
        mul_a = 32'(mul_p[26:0]);
        mul_b = 32'(mf);
      end
      MUL_TD: begin
        mul_a = t_uw;
        mul_b = 32'(dval);
      end
      MUL_GR: begin
        mul_a = 32'(mass_sum);
        mul_b = 32'(GRAV_ROLL_Q16);
      end
      MUL_ROLL: begin
        mul_a = 32'(mul_p[38:16]);
        mul_b = 32'(cfg.rolling_coef_q16);
      end
      MUL_QH: begin
        mul_a = 32'(dq[34:16]);
        mul_b = 32'(KD_RECIP);
      end
      MUL_QL: begin
        mul_a = 32'({q_hi_rem[6:0], dq[15:0]});
        mul_b = 32'(KD_RECIP);
      end
      MUL_SQ: begin
        mul_a = 32'(speed);
        mul_b = 32'(speed);
      end
      MUL_CU: begin
        mul_a = 32'(mul_p[41:16]);
        mul_b = 32'(speed);
      end
      MUL_KD: begin
        mul_a = 32'(kd8);
        mul_b = 32'(mul_p[46:16]);
      end
      MUL_LO: begin
        mul_a = 32'(kr8[23:0]);
        mul_b = 32'(speed);
      end
      MUL_HI: begin
        mul_a = 32'(kr8[39:24]);
        mul_b = 32'(speed);
      end
      MUL_NONE: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctrl.ld_tgt) begin
      tgt <= target_power_mw;
    end
    if (ctrl.ld_t) begin
      t_uw <= mul_p[31:0];
    end
    if (ctrl.ld_num) begin
      dq <= p3[45:11];
    end
    if (ctrl.ld_qh) begin
      kd_hi <= q_hi;
    end
    if (ctrl.ld_kd) begin
      kd8 <= 28'({kd_hi, mul_p[45:30]});
    end
    if (ctrl.ld_thr) begin
      thr_g <= mul_p[41:0] + 42'(dval);
      thr_h <= mul_p[41:0] + 42'(d_tol);
      thr_l <= (mul_p[41:0] >= 42'(d_tol1)) ? mul_p[41:0] - 42'(d_tol1) : '0;
    end
    if (ctrl.ld_kr) begin
      kr8 <= kr_x1000[47:8];
    end
    if (ctrl.srch_init) begin
      speed <= SPEED_W'(SPEED_START_Q16);
      adj   <= SPEED_START_Q16;
    end else if (ctrl.srch_step) begin
      if (!stat.hit) begin
        speed <= high ? spd_down : spd_up;
      end
      adj <= adj >> 1;
    end
    if (ctrl.ld_acc) begin
      acc <= mul_p[57:24];
    end else if (ctrl.add_lo) begin
      acc <= acc + 34'(mul_p[44:24]);
    end
    if (ctrl.ld_wheel) begin
      wheel <= {4'b0, acc} + mul_p[37:0];
    end
    if (ctrl.ld_wk) begin
      wk <= {wheel, 10'b0} - {6'b0, wheel, 4'b0} - {7'b0, wheel, 3'b0};
    end
    if (ctrl.ld_out) begin
      speed_q16 <= speed;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      speed_valid <= 1'b0;
    end else if (ctrl.ld_out) begin
      speed_valid <= 1'b1;
    end else if (!speed_stall) begin
      speed_valid <= 1'b0;
    end
  end

endmodule
